### hdl/act_pkg.sv
// ----------------------------------------------------------------------------
// Area containment test package
// Shared widths, codes and types for the area containment test block.
// ----------------------------------------------------------------------------
package act_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned QW       = 16;
  localparam int unsigned RadiusW  = 23;
  localparam int unsigned ShapeW   = 2;
  localparam int unsigned CountW   = 5;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgShapeType   = 3'd0;
  localparam cfg_idx_t CfgRadius      = 3'd1;
  localparam cfg_idx_t CfgCosHalf     = 3'd2;
  localparam cfg_idx_t CfgCenterX     = 3'd3;
  localparam cfg_idx_t CfgCenterY     = 3'd4;
  localparam cfg_idx_t CfgForwardX    = 3'd5;
  localparam cfg_idx_t CfgForwardY    = 3'd6;
  localparam cfg_idx_t CfgVertexCount = 3'd7;

  localparam logic [ShapeW-1:0] ShapeCircle  = 2'd0;
  localparam logic [ShapeW-1:0] ShapeFan     = 2'd1;
  localparam logic [ShapeW-1:0] ShapePolygon = 2'd2;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  localparam logic [CountW-1:0] MinVertices = 5'd3;

  localparam logic signed [QW-1:0] CosReset  = 16'sh7FFF;
  localparam logic signed [QW-1:0] FwdXReset = 16'sh7FFF;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } vertex_t;

endpackage

### hdl/act_in_if.sv
// ----------------------------------------------------------------------------
// Area containment test input channel
// Valid/ready channel that carries vertex writes and point queries.
// ----------------------------------------------------------------------------
interface act_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [act_pkg::IdxW-1:0]             vertex_index;
  logic signed [act_pkg::CoordW-1:0]    coord_x;
  logic signed [act_pkg::CoordW-1:0]    coord_y;

  modport source (output valid, func, vertex_index, coord_x, coord_y, input ready);
  modport sink (input valid, func, vertex_index, coord_x, coord_y, output ready);
endinterface

### hdl/act_out_if.sv
// ----------------------------------------------------------------------------
// Area containment test result channel
// Valid/ready channel that carries one containment flag per query.
// ----------------------------------------------------------------------------
interface act_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

### hdl/act_cfg_if.sv
// ----------------------------------------------------------------------------
// Area containment test configuration channel
// Valid/ready register write channel with register index and write data.
// ----------------------------------------------------------------------------
interface act_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [act_pkg::CfgIdxW-1:0]    index;
  logic [act_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/act_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module act_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/area_containment_test_top.sv
// ----------------------------------------------------------------------------
// Area containment test
// Decides whether a query point lies inside a circle, a fan or a polygon.
// ----------------------------------------------------------------------------
// Items enter on in_i. An item with func at the write code stores one polygon
// vertex, relative to the center, in the vertex RAM if its vertex_index is below
// MAX_VERTICES, and produces no result. An item with func at the query code
// produces exactly one inside_res item on out_o. Registers are to be written
// over cfg_i only while the block is idle, which the block does not enforce;
// cfg_i is always ready. One query is processed at a time, through a pair of
// shared 32x32 multipliers. A circle query passes the states M1 to M3; a fan
// query that is not settled there goes on through M4 to M8, since the exact
// 82-bit angle compare is built from partial products. In a polygon query the
// RAM delivers one vertex per cycle and each edge passes an add, an operand, a
// multiply and a compare stage.
// The result sits in an output register, so in_i is ready again as soon as
// the result is handed to it. If out_o stalls while a second query finishes,
// that query waits in its final state and in_i stays low until out_o takes
// the earlier result. Reset restores the register defaults and empties the
// output; the vertex RAM is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module area_containment_test_top #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  act_in_if.sink    in_i,
  act_out_if.source out_o,
  act_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_M2   = 4'd2;
  localparam logic [3:0] ST_M3   = 4'd3;
  localparam logic [3:0] ST_M4   = 4'd4;
  localparam logic [3:0] ST_M5   = 4'd5;
  localparam logic [3:0] ST_M6   = 4'd6;
  localparam logic [3:0] ST_M7   = 4'd7;
  localparam logic [3:0] ST_M8   = 4'd8;
  localparam logic [3:0] ST_POLY = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  // Configuration registers.
  logic [act_pkg::ShapeW-1:0]         shape_q;
  logic [act_pkg::RadiusW-1:0]        radius_q;
  logic signed [act_pkg::QW-1:0]      cos_q;
  logic signed [act_pkg::CoordW-1:0]  cx_q, cy_q;
  logic signed [act_pkg::QW-1:0]      fx_q, fy_q;
  logic [act_pkg::CountW-1:0]         vcnt_q;

  // Control.
  logic [3:0]    state_q, state_d;
  logic          res_q, res_d;
  logic          ins_q, ins_d;
  logic          iss_q, iss_d;
  logic [NW-1:0] k_q, k_d;
  logic [NW-1:0] n_q, n_eff;
  logic          out_vld_q, out_vld_d;
  logic          out_res_q;
  logic          s0_vld_q, s0_vld_d, s0_first_q, s0_first_d, s0_last_q, s0_last_d;
  logic          v_vld_q, o_vld_q, m_vld_q;

  // Query datapath.
  logic signed [act_pkg::CoordW-1:0] px_q, py_q;
  logic signed [act_pkg::CoordW:0]   dx_q, dy_q;
  logic signed [63:0]                pa_q, pb_q;
  logic signed [31:0]                ma_a, ma_b, mb_a, mb_b;
  logic [63:0]                       sq_sum;
  logic [49:0]                       d2_q;
  logic signed [40:0]                fdx_q;
  logic signed [41:0]                fdot;
  logic [40:0]                       fa_q;
  logic                              neg_q;
  logic [30:0]                       c2_q;
  logic [81:0]                       lhs_q, rhs_q, rhs;
  logic                              in_circ, fan_res;

  // Polygon pipeline.
  logic                              v_first_q, v_last_q, o_last_q, m_last_q;
  logic                              o_cond_q, m_cond_q, cond, flip;
  logic signed [act_pkg::CoordW:0]   vx_q, vy_q, ox_q, oy_q;
  logic signed [act_pkg::CoordW:0]   ex1, ey1, ex2, ey2, px25;
  logic signed [act_pkg::CoordW+1:0] a1_q, b1_q, a2_q, b2_q;

  // Vertex RAM.
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  act_pkg::vertex_t ram_wdata, ram_rdata;

  logic in_fire, cfg_fire, out_load, few;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  assign n_eff = (32'(vcnt_q) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcnt_q);
  assign few   = (vcnt_q < act_pkg::MinVertices);

  assign ram_we    = in_fire && (in_i.func == act_pkg::FuncWrite) &&
                     (32'(in_i.vertex_index) < 32'(MAX_VERTICES));
  assign ram_waddr = AW'(in_i.vertex_index);
  assign ram_wdata = '{x: in_i.coord_x, y: in_i.coord_y};

  act_ram #(
    .WIDTH($bits(act_pkg::vertex_t)),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared multiplier operands.
  always_comb begin
    ma_a = '0;
    ma_b = '0;
    mb_a = '0;
    mb_b = '0;
    unique case (state_q)
      ST_M1: begin
        ma_a = 32'(dx_q);
        ma_b = 32'(dx_q);
        mb_a = 32'(dy_q);
        mb_b = 32'(dy_q);
      end
      ST_M2: begin
        ma_a = {9'b0, radius_q};
        ma_b = {9'b0, radius_q};
        mb_a = 32'(fx_q);
        mb_b = 32'(dx_q);
      end
      ST_M3: begin
        ma_a = 32'(cos_q);
        ma_b = 32'(cos_q);
        mb_a = 32'(fy_q);
        mb_b = 32'(dy_q);
      end
      ST_M5: begin
        ma_a = {12'b0, fa_q[40:21]};
        ma_b = {12'b0, fa_q[40:21]};
        mb_a = {12'b0, fa_q[40:21]};
        mb_b = {11'b0, fa_q[20:0]};
      end
      ST_M6: begin
        ma_a = {11'b0, fa_q[20:0]};
        ma_b = {11'b0, fa_q[20:0]};
        mb_a = {1'b0, c2_q};
        mb_b = {7'b0, d2_q[24:0]};
      end
      ST_M7: begin
        ma_a = {1'b0, c2_q};
        ma_b = {7'b0, d2_q[49:25]};
      end
      ST_POLY: begin
        ma_a = 32'(a1_q);
        ma_b = 32'(b1_q);
        mb_a = 32'(a2_q);
        mb_b = 32'(b2_q);
      end
      default: begin
      end
    endcase
  end

  assign sq_sum  = pa_q + pb_q;
  assign in_circ = ({14'b0, d2_q} <= $unsigned(pa_q));
  assign fdot    = 42'(fdx_q) + 42'($signed(pb_q[40:0]));
  assign rhs     = rhs_q + ({18'b0, pa_q} << 25);
  assign fan_res = (cos_q >= 0) ? (!neg_q && (lhs_q >= rhs)) : (!neg_q || (lhs_q <= rhs));

  // Edge operands: the current vertex against the previous one.
  assign px25 = 25'(px_q);
  assign cond = ((vx_q < px25) == (px25 <= ox_q));
  always_comb begin
    if (vx_q > ox_q) begin
      ex1 = ox_q;
      ey1 = oy_q;
      ex2 = vx_q;
      ey2 = vy_q;
    end else begin
      ex1 = vx_q;
      ey1 = vy_q;
      ex2 = ox_q;
      ey2 = oy_q;
    end
  end

  assign flip = m_cond_q && (pa_q < pb_q);

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    ins_d      = ins_q;
    iss_d      = iss_q;
    k_d        = k_q;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    s0_vld_d   = 1'b0;
    s0_first_d = 1'b0;
    s0_last_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.func == act_pkg::FuncQuery)) begin
          unique case (shape_q)
            act_pkg::ShapeCircle, act_pkg::ShapeFan: begin
              state_d = ST_M1;
            end
            act_pkg::ShapePolygon: begin
              if (few) begin
                res_d   = 1'b0;
                state_d = ST_DONE;
              end else begin
                state_d = ST_POLY;
                iss_d   = 1'b1;
                k_d     = '0;
                ins_d   = 1'b0;
              end
            end
            default: begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = ST_M3;
      ST_M3: begin
        priority if (shape_q == act_pkg::ShapeCircle) begin
          res_d   = in_circ;
          state_d = ST_DONE;
        end else if (!in_circ) begin
          res_d   = 1'b0;
          state_d = ST_DONE;
        end else if (d2_q == '0) begin
          res_d   = (cos_q <= 0);
          state_d = ST_DONE;
        end else begin
          state_d = ST_M4;
        end
      end
      ST_M4: state_d = ST_M5;
      ST_M5: state_d = ST_M6;
      ST_M6: state_d = ST_M7;
      ST_M7: state_d = ST_M8;
      ST_M8: begin
        res_d   = fan_res;
        state_d = ST_DONE;
      end
      ST_POLY: begin
        if (iss_q) begin
          ram_re     = 1'b1;
          ram_raddr  = (k_q == '0) ? AW'(n_q - NW'(1)) : AW'(k_q - NW'(1));
          s0_vld_d   = 1'b1;
          s0_first_d = (k_q == '0);
          s0_last_d  = (k_q == n_q);
          k_d        = k_q + NW'(1);
          if (k_q == n_q) begin
            iss_d = 1'b0;
          end
        end
        if (m_vld_q) begin
          ins_d = ins_q ^ flip;
          if (m_last_q) begin
            res_d   = ins_q ^ flip;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);
  assign out_vld_d = out_load || (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q   <= act_pkg::ShapeCircle;
      radius_q  <= '0;
      cos_q     <= act_pkg::CosReset;
      cx_q      <= '0;
      cy_q      <= '0;
      fx_q      <= act_pkg::FwdXReset;
      fy_q      <= '0;
      vcnt_q    <= '0;
      state_q   <= ST_IDLE;
      res_q     <= 1'b0;
      ins_q     <= 1'b0;
      iss_q     <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
      s0_vld_q  <= 1'b0;
      v_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_i.index)
          act_pkg::CfgShapeType:   shape_q  <= cfg_i.data[act_pkg::ShapeW-1:0];
          act_pkg::CfgRadius:      radius_q <= cfg_i.data[act_pkg::RadiusW-1:0];
          act_pkg::CfgCosHalf:     cos_q    <= $signed(cfg_i.data[act_pkg::QW-1:0]);
          act_pkg::CfgCenterX:     cx_q     <= $signed(cfg_i.data);
          act_pkg::CfgCenterY:     cy_q     <= $signed(cfg_i.data);
          act_pkg::CfgForwardX:    fx_q     <= $signed(cfg_i.data[act_pkg::QW-1:0]);
          act_pkg::CfgForwardY:    fy_q     <= $signed(cfg_i.data[act_pkg::QW-1:0]);
          act_pkg::CfgVertexCount: vcnt_q   <= cfg_i.data[act_pkg::CountW-1:0];
          default: begin
          end
        endcase
      end
      state_q   <= state_d;
      res_q     <= res_d;
      ins_q     <= ins_d;
      iss_q     <= iss_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
      s0_vld_q  <= s0_vld_d;
      v_vld_q   <= s0_vld_q;
      o_vld_q   <= v_vld_q && !v_first_q;
      m_vld_q   <= o_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= ma_a * ma_b;
    pb_q <= mb_a * mb_b;
    if (out_load) begin
      out_res_q <= res_q;
    end
    if (in_fire) begin
      px_q <= in_i.coord_x;
      py_q <= in_i.coord_y;
      dx_q <= 25'(in_i.coord_x) - 25'(cx_q);
      dy_q <= 25'(in_i.coord_y) - 25'(cy_q);
      n_q  <= n_eff;
    end
    unique case (state_q)
      ST_M2: d2_q <= sq_sum[49:0];
      ST_M3: fdx_q <= $signed(pb_q[40:0]);
      ST_M4: begin
        c2_q  <= pa_q[30:0];
        neg_q <= (fdot < 0);
        fa_q  <= (fdot < 0) ? 41'(-fdot) : 41'(fdot);
      end
      ST_M6: lhs_q <= ({18'b0, pa_q} << 42) + ({18'b0, pb_q} << 22);
      ST_M7: begin
        lhs_q <= lhs_q + {18'b0, pa_q};
        rhs_q <= {18'b0, pb_q};
      end
      default: begin
      end
    endcase
    s0_first_q <= s0_first_d;
    s0_last_q  <= s0_last_d;
    if (s0_vld_q) begin
      vx_q      <= 25'(ram_rdata.x) + 25'(cx_q);
      vy_q      <= 25'(ram_rdata.y) + 25'(cy_q);
      v_first_q <= s0_first_q;
      v_last_q  <= s0_last_q;
    end
    if (v_vld_q) begin
      ox_q     <= vx_q;
      oy_q     <= vy_q;
      o_cond_q <= cond;
      o_last_q <= v_last_q;
      a1_q     <= 26'(py_q) - 26'(ey1);
      b1_q     <= 26'(ex2) - 26'(ex1);
      a2_q     <= 26'(ey2) - 26'(ey1);
      b2_q     <= 26'(px_q) - 26'(ex1);
    end
    m_cond_q <= o_cond_q;
    m_last_q <= o_last_q;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.inside_res = out_res_q;

endmodule

### tb/area_containment_test_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Area containment test testbench
// Runs a short table of directed items through the block, then random
// phases. Each phase first sets every register while the block is idle and
// then sends vertex writes and point queries. A mirror of the registers and
// the vertex table predicts each inside flag that the table does not fix, and
// each result is compared with the oldest open expectation. Both channels idle
// at random.
module area_containment_test_top_test;

  localparam int NumPhases     = 40;
  localparam int PhaseItems    = 25;
  localparam int SettleCycles  = 30;
  localparam int StallLimit    = 2000;
  localparam int FromPredictor = -1;

  localparam logic [act_pkg::ShapeW-1:0] ShapeUnknown = 2'd3;

  typedef enum logic [1:0] {RowCfg, RowWrite, RowQuery} row_kind_t;

  typedef struct packed {
    logic                              func;
    logic [act_pkg::IdxW-1:0]          idx;
    logic signed [act_pkg::CoordW-1:0] x;
    logic signed [act_pkg::CoordW-1:0] y;
  } area_item_t;

  typedef struct {
    row_kind_t         kind;
    act_pkg::cfg_idx_t reg_idx;
    longint            reg_val;
    area_item_t        item;
    int                want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  bit   calm;
  int   mismatches;
  int   stall_cycles;
  int   n_query, n_write, n_hit, n_cfg;
  logic want_bit;

  logic inside_q[$];
  plan_row_t plan[$];

  logic [act_pkg::ShapeW-1:0]        reg_shape;
  logic [act_pkg::RadiusW-1:0]       reg_radius;
  logic signed [act_pkg::QW-1:0]     reg_cos;
  logic signed [act_pkg::CoordW-1:0] reg_cx;
  logic signed [act_pkg::CoordW-1:0] reg_cy;
  logic signed [act_pkg::QW-1:0]     reg_fx;
  logic signed [act_pkg::QW-1:0]     reg_fy;
  logic [act_pkg::CountW-1:0]        reg_count;
  act_pkg::vertex_t                  vert_mem [16];

  act_in_if  in_if ();
  act_out_if out_if ();
  act_cfg_if cfg_if ();

  area_containment_test_top #(
    .MAX_VERTICES(16)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit circle_hit(longint dx, longint dy);
    longint r;
    r = longint'(reg_radius);
    return dx * dx + dy * dy <= r * r;
  endfunction

  function automatic bit fan_hit(longint dx, longint dy);
    longint c, fdot, fa, d2, c2;
    logic [127:0] fa_w, c2_w, d2_w, lhs, rhs;
    if (!circle_hit(dx, dy)) return 1'b0;
    c = longint'(reg_cos);
    if (dx == 0 && dy == 0) return c <= 0;
    fdot = longint'(reg_fx) * dx + longint'(reg_fy) * dy;
    d2 = dx * dx + dy * dy;
    c2 = c * c;
    fa = (fdot < 0) ? -fdot : fdot;
    fa_w = fa;
    c2_w = c2;
    d2_w = d2;
    lhs = fa_w * fa_w;
    rhs = c2_w * d2_w;
    if (c >= 0) begin
      if (fdot < 0) return 1'b0;
      return lhs >= rhs;
    end
    if (fdot >= 0) return 1'b1;
    return lhs <= rhs;
  endfunction

  function automatic bit polygon_hit(longint px, longint py);
    int n;
    bit hit;
    longint cx, cy, xold, yold, xnew, ynew, x1, y1, x2, y2;
    n = reg_count;
    hit = 1'b0;
    if (n < 3) return 1'b0;
    if (n > 16) n = 16;
    cx = longint'(reg_cx);
    cy = longint'(reg_cy);
    xold = longint'($signed(vert_mem[n-1].x)) + cx;
    yold = longint'($signed(vert_mem[n-1].y)) + cy;
    for (int i = 0; i < n; i++) begin
      xnew = longint'($signed(vert_mem[i].x)) + cx;
      ynew = longint'($signed(vert_mem[i].y)) + cy;
      if (xnew > xold) begin
        x1 = xold; x2 = xnew; y1 = yold; y2 = ynew;
      end else begin
        x1 = xnew; x2 = xold; y1 = ynew; y2 = yold;
      end
      if (((xnew < px) == (px <= xold)) && ((py - y1) * (x2 - x1) < (y2 - y1) * (px - x1)))
        hit = !hit;
      xold = xnew;
      yold = ynew;
    end
    return hit;
  endfunction

  function automatic logic area_hit(area_item_t it);
    longint px, py, dx, dy;
    px = longint'($signed(it.x));
    py = longint'($signed(it.y));
    dx = px - longint'(reg_cx);
    dy = py - longint'(reg_cy);
    case (reg_shape)
      act_pkg::ShapeCircle:  return circle_hit(dx, dy);
      act_pkg::ShapeFan:     return fan_hit(dx, dy);
      act_pkg::ShapePolygon: return polygon_hit(px, py);
      default:               return 1'b0;
    endcase
  endfunction

  function automatic longint rand_offset(longint lim);
    return longint'($urandom_range(32'(2 * lim))) - lim;
  endfunction

  function automatic longint pick_reg(int phase, longint lo, longint hi, longint normal);
    if (phase == 0) return hi;
    if (phase == 1) return lo;
    if ($urandom_range(7) == 0) return $urandom_range(1) ? hi : lo;
    return normal;
  endfunction

  function automatic area_item_t make_item(logic func, int idx, longint x, longint y);
    area_item_t it;
    it.func = func;
    it.idx  = idx[act_pkg::IdxW-1:0];
    it.x    = x[act_pkg::CoordW-1:0];
    it.y    = y[act_pkg::CoordW-1:0];
    return it;
  endfunction

  function automatic plan_row_t cfg_row(act_pkg::cfg_idx_t r, longint v);
    plan_row_t row;
    row.kind    = RowCfg;
    row.reg_idx = r;
    row.reg_val = v;
    row.item    = '0;
    row.want    = FromPredictor;
    return row;
  endfunction

  function automatic plan_row_t write_row(int idx, longint x, longint y);
    plan_row_t row;
    row.kind    = RowWrite;
    row.reg_idx = act_pkg::CfgShapeType;
    row.reg_val = 0;
    row.item    = make_item(act_pkg::FuncWrite, idx, x, y);
    row.want    = FromPredictor;
    return row;
  endfunction

  function automatic plan_row_t query_row(longint x, longint y, int want);
    plan_row_t row;
    row.kind    = RowQuery;
    row.reg_idx = act_pkg::CfgShapeType;
    row.reg_val = 0;
    row.item    = make_item(act_pkg::FuncQuery, 0, x, y);
    row.want    = want;
    return row;
  endfunction

  task automatic send_item(input area_item_t it, input int want);
    while (!calm && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= it.func;
    in_if.vertex_index <= it.idx;
    in_if.coord_x      <= it.x;
    in_if.coord_y      <= it.y;
    do @(posedge clk); while (!in_if.ready);
    if (it.func == act_pkg::FuncWrite) begin
      vert_mem[it.idx].x = it.x;
      vert_mem[it.idx].y = it.y;
      n_write++;
    end else begin
      if (want == FromPredictor) inside_q.push_back(area_hit(it));
      else inside_q.push_back(want[0]);
      n_hit += inside_q[$];
      n_query++;
    end
  endtask

  task automatic write_reg(input act_pkg::cfg_idx_t idx, input longint v);
    int w;
    logic [act_pkg::CfgDataW-1:0] data;
    case (idx)
      act_pkg::CfgShapeType:   w = act_pkg::ShapeW;
      act_pkg::CfgRadius:      w = act_pkg::RadiusW;
      act_pkg::CfgCosHalf:     w = act_pkg::QW;
      act_pkg::CfgForwardX:    w = act_pkg::QW;
      act_pkg::CfgForwardY:    w = act_pkg::QW;
      act_pkg::CfgVertexCount: w = act_pkg::CountW;
      default:                 w = act_pkg::CoordW;
    endcase
    data = act_pkg::CfgDataW'(v) & ((24'h1 << w) - 24'h1);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      act_pkg::CfgShapeType:   reg_shape  = data[act_pkg::ShapeW-1:0];
      act_pkg::CfgRadius:      reg_radius = data[act_pkg::RadiusW-1:0];
      act_pkg::CfgCosHalf:     reg_cos    = data[act_pkg::QW-1:0];
      act_pkg::CfgCenterX:     reg_cx     = data;
      act_pkg::CfgCenterY:     reg_cy     = data;
      act_pkg::CfgForwardX:    reg_fx     = data[act_pkg::QW-1:0];
      act_pkg::CfgForwardY:    reg_fy     = data[act_pkg::QW-1:0];
      act_pkg::CfgVertexCount: reg_count  = data[act_pkg::CountW-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (inside_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= 13);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (inside_q.size() == 0) begin
        $error("inside_res: expected no item, actual %0b", out_if.inside_res);
        mismatches++;
      end else begin
        want_bit = inside_q.pop_front();
        if (out_if.inside_res !== want_bit) begin
          $error("inside_res: expected %0b, actual %0b", want_bit, out_if.inside_res);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("area_containment_test_top test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    bit in_cfg;
    longint scale, lim, x, y;
    int nverts;
    logic [act_pkg::ShapeW-1:0] shape;
    in_if.valid        <= 1'b0;
    in_if.func         <= act_pkg::FuncWrite;
    in_if.vertex_index <= '0;
    in_if.coord_x      <= '0;
    in_if.coord_y      <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= act_pkg::CfgShapeType;
    cfg_if.data        <= '0;
    rst_n              <= 1'b0;
    calm = 1'b0;
    in_cfg = 1'b0;
    mismatches = 0;
    n_query = 0;
    n_write = 0;
    n_hit = 0;
    n_cfg = 0;
    reg_shape  = act_pkg::ShapeCircle;
    reg_radius = '0;
    reg_cos    = act_pkg::CosReset;
    reg_cx     = '0;
    reg_cy     = '0;
    reg_fx     = act_pkg::FwdXReset;
    reg_fy     = '0;
    reg_count  = '0;

    plan.push_back(query_row(0, 0, 1));
    plan.push_back(query_row(1, 0, 0));
    plan.push_back(query_row(-8388608, -8388608, 0));
    plan.push_back(cfg_row(act_pkg::CfgRadius, 8388607));
    plan.push_back(query_row(8388607, 0, 1));
    plan.push_back(query_row(-8388608, -8388608, 0));
    plan.push_back(query_row(8388607, 8388607, 0));
    plan.push_back(cfg_row(act_pkg::CfgShapeType, act_pkg::ShapeFan));
    plan.push_back(cfg_row(act_pkg::CfgRadius, 1000));
    plan.push_back(query_row(0, 0, 0));
    plan.push_back(query_row(500, 0, 1));
    plan.push_back(query_row(500, 1, FromPredictor));
    plan.push_back(cfg_row(act_pkg::CfgCosHalf, 0));
    plan.push_back(query_row(0, 0, 1));
    plan.push_back(query_row(0, 500, FromPredictor));
    plan.push_back(query_row(-1, 500, FromPredictor));
    plan.push_back(cfg_row(act_pkg::CfgCosHalf, -32768));
    plan.push_back(query_row(-500, 0, FromPredictor));
    plan.push_back(cfg_row(act_pkg::CfgCenterX, -8388608));
    plan.push_back(cfg_row(act_pkg::CfgCenterY, 8388607));
    plan.push_back(cfg_row(act_pkg::CfgForwardX, -32768));
    plan.push_back(cfg_row(act_pkg::CfgForwardY, 32767));
    plan.push_back(query_row(-8388608, 8388607, 1));
    plan.push_back(query_row(-8388000, 8388000, FromPredictor));
    plan.push_back(cfg_row(act_pkg::CfgShapeType, act_pkg::ShapePolygon));
    plan.push_back(cfg_row(act_pkg::CfgVertexCount, 2));
    plan.push_back(cfg_row(act_pkg::CfgCenterX, 0));
    plan.push_back(cfg_row(act_pkg::CfgCenterY, 0));
    plan.push_back(query_row(0, 0, 0));
    plan.push_back(write_row(0, -100, -100));
    plan.push_back(write_row(1, 100, -100));
    plan.push_back(write_row(2, 100, 100));
    plan.push_back(write_row(3, -100, 100));
    plan.push_back(write_row(15, 8388607, -8388608));
    plan.push_back(cfg_row(act_pkg::CfgVertexCount, 4));
    plan.push_back(query_row(0, 0, FromPredictor));
    plan.push_back(query_row(200, 0, FromPredictor));
    plan.push_back(cfg_row(act_pkg::CfgShapeType, ShapeUnknown));
    plan.push_back(query_row(0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1'b1;
        end
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (in_cfg) begin
          cfg_if.valid <= 1'b0;
          in_cfg = 1'b0;
        end
        send_item(plan[i].item, plan[i].want);
      end
    end
    if (in_cfg) cfg_if.valid <= 1'b0;

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      calm = (phase >= 18 && phase < 24);
      scale = 64'd1 << $urandom_range(23, 3);
      shape = (phase % 4 == 3) ? 2'($urandom_range(3)) : 2'(phase % 4);
      write_reg(act_pkg::CfgShapeType, shape);
      write_reg(act_pkg::CfgRadius,
                pick_reg(phase, 0, 8388607, $urandom_range(32'(scale - 1))));
      write_reg(act_pkg::CfgCosHalf, pick_reg(phase, -32768, 32767, rand_offset(32767)));
      write_reg(act_pkg::CfgCenterX,
                pick_reg(phase, -8388608, 8388607, rand_offset(8388607)));
      write_reg(act_pkg::CfgCenterY,
                pick_reg(phase, -8388608, 8388607, rand_offset(8388607)));
      write_reg(act_pkg::CfgForwardX, pick_reg(phase, -32768, 32767, rand_offset(32767)));
      write_reg(act_pkg::CfgForwardY, pick_reg(phase, -32768, 32767, rand_offset(32767)));
      write_reg(act_pkg::CfgVertexCount, pick_reg(phase, 0, 31,
        (shape == act_pkg::ShapePolygon) ? $urandom_range(16, 3) : $urandom_range(31)));
      cfg_if.valid <= 1'b0;

      // A polygon query reads every vertex in use, so load them all first.
      if (reg_shape == act_pkg::ShapePolygon) begin
        nverts = (reg_count > 16) ? 16 : reg_count;
        for (int v = 0; v < nverts; v++)
          send_item(make_item(act_pkg::FuncWrite, v, rand_offset(scale), rand_offset(scale)),
                    FromPredictor);
      end

      lim = (reg_shape == act_pkg::ShapePolygon) ? scale : 2 * scale;
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(15) == 0) begin
            x = $urandom;
            y = $urandom;
          end else begin
            x = rand_offset(scale);
            y = rand_offset(scale);
          end
          send_item(make_item(act_pkg::FuncWrite, $urandom_range(15), x, y), FromPredictor);
        end else begin
          if ($urandom_range(9) == 0) begin
            x = $urandom;
            y = $urandom;
          end else begin
            x = longint'(reg_cx) + rand_offset(lim);
            y = longint'(reg_cy) + rand_offset(lim);
          end
          send_item(make_item(act_pkg::FuncQuery, $urandom_range(15), x, y), FromPredictor);
        end
      end
    end
    calm = 1'b0;
    settle();

    $display("Covered %0d point queries (%0d inside) and %0d vertex writes,", n_query, n_hit,
             n_write);
    $display("with %0d register writes over %0d random phases of circle, fan and polygon.",
             n_cfg, NumPhases);
    if (mismatches == 0) begin
      $display("area_containment_test_top test passed");
    end else begin
      $display("area_containment_test_top test failed");
    end
    $finish;
  end

endmodule
